// File: sv/mtfe_pkg.sv
// Shared types and constants of the motor target frame encoder.
// Depends on nothing; every other file refers to it by scoped names.
package mtfe_pkg;

    // pi in Q32
    localparam logic [33:0] PI_Q32 = 34'h3243F6A89;

    // Reciprocal of pi for the angle scale: floor(2^79 / PI_Q32), split in two halves
    localparam int ANG_RECIP_W = 46;
    localparam int ANG_LO_W    = 23;
    localparam int ANG_HI_W    = ANG_RECIP_W - ANG_LO_W;
    localparam logic [127:0] ANG_RECIP_WIDE = (128'd1 << 79) / 128'(PI_Q32);
    localparam logic [ANG_RECIP_W-1:0] ANG_RECIP = ANG_RECIP_W'(ANG_RECIP_WIDE);

    // Reciprocal for the speed scale: floor(180 * 2^80 / PI_Q32), split in two halves
    localparam int SPD_RECIP_W = 54;
    localparam int SPD_LO_W    = 27;
    localparam int SPD_HI_W    = SPD_RECIP_W - SPD_LO_W;
    localparam logic [127:0] SPD_RECIP_WIDE = (128'd180 << 80) / 128'(PI_Q32);
    localparam logic [SPD_RECIP_W-1:0] SPD_RECIP = SPD_RECIP_W'(SPD_RECIP_WIDE);

    // Code ranges of the three encodings
    localparam logic [11:0] ANG_CODE_MAX = 12'd4095;
    localparam logic [18:0] SPD_CODE_MAX = 19'd524287;
    localparam logic [10:0] DTY_CODE_MAX = 11'd2047;
    localparam logic [7:0]  FILL_BYTE    = 8'hFF;

    // Configuration register indexes
    localparam logic [0:0] REG_DRIVER_NUMBER = 1'b0;
    localparam logic [0:0] REG_ENCODER_MODE  = 1'b1;

    typedef enum logic [1:0] {
        MODE_ANGLE = 2'd0,
        MODE_SPEED = 2'd1,
        MODE_DUTY  = 2'd2,
        MODE_POV   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_SENT       = 2'd0,
        ST_SUPPRESSED = 2'd1,
        ST_RANGE      = 2'd2
    } t_status;

    // Encoded frame before the repeat check
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       ok;
    } t_frame;

endpackage

// File: sv/mtfe_scale.sv
// Product stage: registers the target together with the partial products of the
// angle and speed reciprocal multiplies. Depends on mtfe_pkg.
module mtfe_scale #(
    parameter int TARGET_FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_valid,
    input  logic signed [31:0]  i_target,
    input  logic                i_flag,
    output logic                o_valid,
    output logic signed [31:0]  o_target,
    output logic                o_flag,
    output logic signed [TARGET_FRACTION_BITS+mtfe_pkg::ANG_LO_W+3:0] o_ang_lo,
    output logic signed [TARGET_FRACTION_BITS+mtfe_pkg::ANG_HI_W+3:0] o_ang_hi,
    output logic signed [TARGET_FRACTION_BITS+mtfe_pkg::SPD_LO_W-2:0] o_spd_lo,
    output logic signed [TARGET_FRACTION_BITS+mtfe_pkg::SPD_HI_W-2:0] o_spd_hi
);

    localparam int F  = TARGET_FRACTION_BITS;
    // angle targets stay within +-pi, speed targets that matter within +-1/16
    localparam int AW = F + 3;
    localparam int SW = F - 2;

    logic signed [AW-1:0] ang_t;
    logic signed [SW-1:0] spd_t;
    logic signed [AW+mtfe_pkg::ANG_LO_W:0] n_ang_lo;
    logic signed [AW+mtfe_pkg::ANG_HI_W:0] n_ang_hi;
    logic signed [SW+mtfe_pkg::SPD_LO_W:0] n_spd_lo;
    logic signed [SW+mtfe_pkg::SPD_HI_W:0] n_spd_hi;

    logic r_valid;
    logic signed [31:0] r_target;
    logic r_flag;
    logic signed [AW+mtfe_pkg::ANG_LO_W:0] r_ang_lo;
    logic signed [AW+mtfe_pkg::ANG_HI_W:0] r_ang_hi;
    logic signed [SW+mtfe_pkg::SPD_LO_W:0] r_spd_lo;
    logic signed [SW+mtfe_pkg::SPD_HI_W:0] r_spd_hi;

    // Narrow the target to the span each scale can use
    assign ang_t = $signed(i_target[AW-1:0]);
    assign spd_t = $signed(i_target[SW-1:0]);

    // Split multiplies against the reciprocal halves
    assign n_ang_lo = ang_t *
        $signed({1'b0, mtfe_pkg::ANG_RECIP[mtfe_pkg::ANG_LO_W-1:0]});
    assign n_ang_hi = ang_t *
        $signed({1'b0, mtfe_pkg::ANG_RECIP[mtfe_pkg::ANG_RECIP_W-1:mtfe_pkg::ANG_LO_W]});
    assign n_spd_lo = spd_t *
        $signed({1'b0, mtfe_pkg::SPD_RECIP[mtfe_pkg::SPD_LO_W-1:0]});
    assign n_spd_hi = spd_t *
        $signed({1'b0, mtfe_pkg::SPD_RECIP[mtfe_pkg::SPD_RECIP_W-1:mtfe_pkg::SPD_LO_W]});

    // Stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Hold the request and its products
    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_target <= i_target;
            r_flag   <= i_flag;
            r_ang_lo <= n_ang_lo;
            r_ang_hi <= n_ang_hi;
            r_spd_lo <= n_spd_lo;
            r_spd_hi <= n_spd_hi;
        end
    end

    assign o_valid  = r_valid;
    assign o_target = r_target;
    assign o_flag   = r_flag;
    assign o_ang_lo = r_ang_lo;
    assign o_ang_hi = r_ang_hi;
    assign o_spd_lo = r_spd_lo;
    assign o_spd_hi = r_spd_hi;

endmodule

// File: sv/mtfe_encode.sv
// Frame encoder: range checks, scaling, saturation and byte packing of one target.
// Pure combinational logic. Depends on mtfe_pkg.
module mtfe_encode #(
    parameter int TARGET_FRACTION_BITS = 16
) (
    input  logic signed [31:0]     i_target,
    input  logic                   i_flag,
    input  logic signed [TARGET_FRACTION_BITS+mtfe_pkg::ANG_LO_W+3:0] i_ang_lo,
    input  logic signed [TARGET_FRACTION_BITS+mtfe_pkg::ANG_HI_W+3:0] i_ang_hi,
    input  logic signed [TARGET_FRACTION_BITS+mtfe_pkg::SPD_LO_W-2:0] i_spd_lo,
    input  logic signed [TARGET_FRACTION_BITS+mtfe_pkg::SPD_HI_W-2:0] i_spd_hi,
    input  logic [3:0]             i_driver,
    input  mtfe_pkg::t_mode        i_mode,
    output mtfe_pkg::t_frame       o_frame
);

    localparam int F    = TARGET_FRACTION_BITS;
    localparam int S    = 32 - F;
    localparam int AW   = F + 3;
    localparam int SW   = F - 2;
    localparam int MW   = F + 1;
    // sum widths and the shifts that turn the products into codes
    localparam int YA_W = AW + mtfe_pkg::ANG_RECIP_W + 1;
    localparam int WA   = F + 36;
    localparam int QA_W = YA_W - WA;
    localparam int YS_W = SW + mtfe_pkg::SPD_RECIP_W + 1;
    localparam int WS   = F + 30;
    localparam int QS_W = YS_W - WS;

    localparam logic signed [31:0] ONE_S = 32'sd1 <<< F;
    localparam logic signed [31:0] LIM_S = 32'sd1 <<< (F - 4);
    localparam logic [F+1:0]       ONE_U = {2'b01, {F{1'b0}}};
    localparam logic signed [63:0] ANG_T_MAX  = $signed(64'(mtfe_pkg::PI_Q32) >> S);
    localparam logic signed [63:0] ANG_T_EXCL =
        -$signed((64'(mtfe_pkg::PI_Q32) + (64'd1 << S) - 64'd1) >> S);

    logic signed [63:0] t_wide;
    logic               duty_ok;
    logic               ang_ok;
    logic               neg;
    logic [F+1:0]       tp1;
    logic [F+12:0]      ad_sh;
    logic [F+19:0]      sd_sh;
    logic [MW-1:0]      mag;
    logic [F+10:0]      dm_sh;
    logic [10:0]        trm;
    logic [11:0]        dm_v;
    logic signed [YA_W-1:0] y_ang;
    logic signed [QA_W-1:0] q_ang;
    logic signed [QA_W+1:0] va_s;
    logic signed [YS_W-1:0] y_spd;
    logic signed [QS_W-1:0] q_spd;
    logic signed [QS_W:0]   vs_s;
    logic [11:0]        ang_duty_v;
    logic [11:0]        ang_v;
    logic [18:0]        spd_duty_v;
    logic [18:0]        spd_v;
    logic [10:0]        duty_v;

    // Range checks
    assign t_wide  = 64'(i_target);
    assign duty_ok = (i_target >= -ONE_S) && (i_target <= ONE_S);
    assign ang_ok  = (t_wide <= ANG_T_MAX) && (t_wide > ANG_T_EXCL);

    // Duty fraction shifted to 0..2 and scaled to 12 or 19 bits
    assign tp1        = i_target[F+1:0] + ONE_U;
    assign ad_sh      = {tp1, 11'b0};
    assign sd_sh      = {tp1, 18'b0};
    assign ang_duty_v = ad_sh[F+12] ? mtfe_pkg::ANG_CODE_MAX : ad_sh[F+11:F];
    assign spd_duty_v = sd_sh[F+19] ? mtfe_pkg::SPD_CODE_MAX : sd_sh[F+18:F];

    // Duty mode: truncate toward zero on the magnitude, then recenter at 1024
    assign neg    = i_target[31];
    assign mag    = neg ? MW'(-i_target) : i_target[MW-1:0];
    assign dm_sh  = {mag, 10'b0};
    assign trm    = dm_sh[F+10:F];
    assign dm_v   = neg ? (12'd1024 - 12'(trm)) : (12'd1024 + 12'(trm));
    assign duty_v = dm_v[11] ? mtfe_pkg::DTY_CODE_MAX : dm_v[10:0];

    // Angle: floor of the reciprocal product, offset and clamp
    assign y_ang = (YA_W'(i_ang_hi) <<< mtfe_pkg::ANG_LO_W) + YA_W'(i_ang_lo);
    assign q_ang = $signed(y_ang[YA_W-1:WA]);
    assign va_s  = (QA_W+2)'(q_ang) + (QA_W+2)'(2047);

    always_comb begin
        if (va_s < 0) begin
            ang_v = '0;
        end else if (va_s > $signed((QA_W+2)'(mtfe_pkg::ANG_CODE_MAX))) begin
            ang_v = mtfe_pkg::ANG_CODE_MAX;
        end else begin
            ang_v = va_s[11:0];
        end
    end

    // Speed: saturate large targets outright, else floor, offset and clamp
    assign y_spd = (YS_W'(i_spd_hi) <<< mtfe_pkg::SPD_LO_W) + YS_W'(i_spd_lo);
    assign q_spd = $signed(y_spd[YS_W-1:WS]);
    assign vs_s  = (QS_W+1)'(q_spd) + (QS_W+1)'(262144);

    always_comb begin
        if (i_target > LIM_S) begin
            spd_v = mtfe_pkg::SPD_CODE_MAX;
        end else if (i_target < -LIM_S) begin
            spd_v = '0;
        end else if (vs_s < 0) begin
            spd_v = '0;
        end else if (vs_s > $signed((QS_W+1)'(mtfe_pkg::SPD_CODE_MAX))) begin
            spd_v = mtfe_pkg::SPD_CODE_MAX;
        end else begin
            spd_v = vs_s[18:0];
        end
    end

    // Pack bytes by encoder mode
    always_comb begin
        o_frame = '0;
        case (i_mode)
            mtfe_pkg::MODE_ANGLE: begin
                if (i_flag) begin
                    o_frame.ok  = duty_ok;
                    o_frame.b0  = {ang_duty_v[11:8], i_driver};
                    o_frame.b1  = ang_duty_v[7:0];
                    o_frame.b2  = mtfe_pkg::FILL_BYTE;
                    o_frame.cnt = 2'd3;
                end else begin
                    o_frame.ok  = ang_ok;
                    o_frame.b0  = {ang_v[11:8], i_driver};
                    o_frame.b1  = ang_v[7:0];
                    o_frame.cnt = 2'd2;
                end
            end
            mtfe_pkg::MODE_DUTY: begin
                o_frame.ok  = duty_ok;
                o_frame.b0  = {duty_v[10:8], 1'b0, i_driver};
                o_frame.b1  = duty_v[7:0];
                o_frame.cnt = 2'd2;
            end
            // speed and pov share one encoding
            default: begin
                o_frame.cnt = 2'd3;
                if (i_flag) begin
                    o_frame.ok = duty_ok;
                    o_frame.b0 = {spd_duty_v[18:16], 1'b1, i_driver};
                    o_frame.b1 = spd_duty_v[15:8];
                    o_frame.b2 = spd_duty_v[7:0];
                end else begin
                    o_frame.ok = 1'b1;
                    o_frame.b0 = {spd_v[18:16], 1'b0, i_driver};
                    o_frame.b1 = spd_v[15:8];
                    o_frame.b2 = spd_v[7:0];
                end
            end
        endcase
    end

endmodule

// File: sv/motor_target_frame_encoder.sv
// Top level of the motor target frame encoder: handshakes, configuration,
// repeat suppression and result register. Depends on mtfe_pkg, mtfe_scale, mtfe_encode.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_stall    i_target_value, i_duty_request
//   out       source     o_out_valid / i_out_stall  o_byte_zero..two, o_byte_count,
//                                                   o_send_status
//   cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request per cycle while the output is not stalled; each passes through the stages below.
// Three stages: input register, reciprocal partial products, encode and repeat check
// against the last sent target into the result register.
// Synchronous active-low reset clears stage valids, configuration and the last target.
// A stalled result holds; input keeps flowing while any stage has a free slot.
module motor_target_frame_encoder #(
    parameter int TARGET_FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_target_value,
    input  logic               i_duty_request,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_byte_zero,
    output logic [7:0]         o_byte_one,
    output logic [7:0]         o_byte_two,
    output logic [1:0]         o_byte_count,
    output logic [1:0]         o_send_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    localparam int F = TARGET_FRACTION_BITS;

    logic out_load;
    logic mid_load;
    logic in_load;

    logic               r_s0_valid;
    logic signed [31:0] r_s0_target;
    logic               r_s0_flag;

    logic               s1_valid;
    logic signed [31:0] s1_target;
    logic               s1_flag;
    logic signed [F+mtfe_pkg::ANG_LO_W+3:0] s1_ang_lo;
    logic signed [F+mtfe_pkg::ANG_HI_W+3:0] s1_ang_hi;
    logic signed [F+mtfe_pkg::SPD_LO_W-2:0] s1_spd_lo;
    logic signed [F+mtfe_pkg::SPD_HI_W-2:0] s1_spd_hi;

    mtfe_pkg::t_frame   frame;
    logic               suppress;
    logic               commit;

    logic [3:0]         r_driver;
    mtfe_pkg::t_mode    r_mode;

    logic               r_last_valid;
    logic signed [31:0] r_last_target;
    logic               r_last_flag;

    logic               r_out_valid;
    logic [7:0]         r_b0;
    logic [7:0]         r_b1;
    logic [7:0]         r_b2;
    logic [1:0]         r_cnt;
    mtfe_pkg::t_status  r_status;
    logic [7:0]         n_b0;
    logic [7:0]         n_b1;
    logic [7:0]         n_b2;
    logic [1:0]         n_cnt;
    mtfe_pkg::t_status  n_status;

    // Advance each stage when it is empty or its successor moves
    assign out_load   = !r_out_valid || !i_out_stall;
    assign mid_load   = !s1_valid || out_load;
    assign in_load    = !r_s0_valid || mid_load;
    assign o_in_stall = !in_load;

    // Configuration writes land at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_driver <= 4'd0;
            r_mode   <= mtfe_pkg::MODE_ANGLE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mtfe_pkg::REG_DRIVER_NUMBER: r_driver <= i_cfg_data;
                mtfe_pkg::REG_ENCODER_MODE:  r_mode   <= mtfe_pkg::t_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (in_load) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_s0_target <= i_target_value;
            r_s0_flag   <= i_duty_request;
        end
    end

    mtfe_scale #(
        .TARGET_FRACTION_BITS(TARGET_FRACTION_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mid_load),
        .i_valid  (r_s0_valid),
        .i_target (r_s0_target),
        .i_flag   (r_s0_flag),
        .o_valid  (s1_valid),
        .o_target (s1_target),
        .o_flag   (s1_flag),
        .o_ang_lo (s1_ang_lo),
        .o_ang_hi (s1_ang_hi),
        .o_spd_lo (s1_spd_lo),
        .o_spd_hi (s1_spd_hi)
    );

    mtfe_encode #(
        .TARGET_FRACTION_BITS(TARGET_FRACTION_BITS)
    ) u_encode (
        .i_target (s1_target),
        .i_flag   (s1_flag),
        .i_ang_lo (s1_ang_lo),
        .i_ang_hi (s1_ang_hi),
        .i_spd_lo (s1_spd_lo),
        .i_spd_hi (s1_spd_hi),
        .i_driver (r_driver),
        .i_mode   (r_mode),
        .o_frame  (frame)
    );

    // Drop a request equal to the last sent one, whatever the mode
    assign suppress = r_last_valid && (s1_flag == r_last_flag) && (s1_target == r_last_target);
    assign commit   = out_load && s1_valid && !suppress && frame.ok;

    always_comb begin
        n_b0     = '0;
        n_b1     = '0;
        n_b2     = '0;
        n_cnt    = '0;
        n_status = mtfe_pkg::ST_SENT;
        if (suppress) begin
            n_status = mtfe_pkg::ST_SUPPRESSED;
        end else if (!frame.ok) begin
            n_status = mtfe_pkg::ST_RANGE;
        end else begin
            n_b0  = frame.b0;
            n_b1  = frame.b1;
            n_b2  = frame.b2;
            n_cnt = frame.cnt;
        end
    end

    // Remember the last sent target and flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid  <= 1'b0;
            r_last_target <= '0;
            r_last_flag   <= 1'b0;
        end else if (commit) begin
            r_last_valid  <= 1'b1;
            r_last_target <= s1_target;
            r_last_flag   <= s1_flag;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && s1_valid) begin
            r_b0     <= n_b0;
            r_b1     <= n_b1;
            r_b2     <= n_b2;
            r_cnt    <= n_cnt;
            r_status <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_zero   = r_b0;
    assign o_byte_one    = r_b1;
    assign o_byte_two    = r_b2;
    assign o_byte_count  = r_cnt;
    assign o_send_status = r_status;

    // A blocked input stage keeps its request
    a_s0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_valid && !mid_load) |=>
            (r_s0_valid && $stable(r_s0_target) && $stable(r_s0_flag)))
        else $error("input stage lost or changed a blocked request");

    // Input stalls only when every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s0_valid && s1_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // Only a sent frame carries bytes
    a_count_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_send_status == mtfe_pkg::ST_SENT) == (o_byte_count != 2'd0)))
        else $error("byte count disagrees with send status");

    // A sent frame becomes the new reference for suppression
    a_last_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_last_valid && (r_last_target == $past(s1_target))))
        else $error("last target not updated after a sent frame");

endmodule

// File: dv/tb_motor_target_frame_encoder.sv
// Testbench for motor_target_frame_encoder: predicts every frame payload and status and
// compares it with the block's output in order, under random valid/stall gaps.
// Depends on mtfe_pkg and motor_target_frame_encoder from the sv folder.
`timescale 1ns / 1ps

module tb_motor_target_frame_encoder;

    localparam int     FRAC       = 16;
    localparam longint ONE        = 64'sd1 << FRAC;
    localparam longint Q32_SCALE  = 64'sd1 << (32 - FRAC);
    localparam longint PI_FIX     = 64'sh3243F6A89;
    localparam longint ANG_T      = PI_FIX >>> (32 - FRAC);
    localparam longint SPD_LIM    = ONE >>> 4;
    localparam longint SPD_MID    = 64'sd262144;
    localparam longint SPD_MAX    = 64'sd524287;
    localparam longint ANG_MAX    = 64'sd4095;
    localparam longint DTY_MAX    = 64'sd2047;
    localparam int     LONG_HOLD  = 300;
    localparam int     PHASES     = 12;
    localparam int     PHASE_REQS = 150;

    typedef struct packed {
        logic [31:0] target;
        logic        duty;
    } t_request;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic [1:0] status;
    } t_result;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_target_value = '0;
    logic               i_duty_request = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [7:0]         o_byte_zero;
    logic [7:0]         o_byte_one;
    logic [7:0]         o_byte_two;
    logic [1:0]         o_byte_count;
    logic [1:0]         o_send_status;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index    = '0;
    logic [3:0]         i_cfg_data     = '0;

    motor_target_frame_encoder #(
        .TARGET_FRACTION_BITS(FRAC)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_target_value (i_target_value),
        .i_duty_request (i_duty_request),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_zero    (o_byte_zero),
        .o_byte_one     (o_byte_one),
        .o_byte_two     (o_byte_two),
        .o_byte_count   (o_byte_count),
        .o_send_status  (o_send_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Predicted configuration and last-sent state
    logic [3:0]       cfg_driver = '0;
    mtfe_pkg::t_mode  cfg_mode   = mtfe_pkg::MODE_ANGLE;
    logic [31:0]      last_sent_target = '0;
    logic             last_sent_duty   = 1'b0;
    logic             sent_once        = 1'b0;

    t_request pending_requests[$];
    t_result  expected_frames[$];
    t_request current_request;
    int       issued_count   = 0;
    int       accepted_count = 0;
    int       mismatches     = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;
    int       send_wait      = 0;
    int       recv_wait      = 0;
    int       hold_left      = 0;
    logic     hold_toggle    = 1'b0;
    logic     hold_seen      = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint div_floor(longint n, longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int draw_wait(int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(1, 15);
        return 0;
    endfunction

    // Build the expected payload for one request and advance the last-sent state
    function automatic t_result encode_frame(t_request rq);
        longint  t;
        longint  tq;
        longint  v;
        longint  m;
        logic    duty_ok;
        t_result f;
        f       = '0;
        t       = longint'($signed(rq.target));
        tq      = t * Q32_SCALE;
        duty_ok = (t >= -ONE) && (t <= ONE);
        if (sent_once && rq.duty == last_sent_duty && rq.target == last_sent_target) begin
            f.status = mtfe_pkg::ST_SUPPRESSED;
            return f;
        end
        f.status = mtfe_pkg::ST_RANGE;
        case (cfg_mode)
            mtfe_pkg::MODE_ANGLE: begin
                if (rq.duty) begin
                    if (!duty_ok)
                        return f;
                    v     = sat(((t + ONE) * 2048) >>> FRAC, 0, ANG_MAX);
                    f.b2  = 8'hFF;
                    f.cnt = 2'd3;
                end else begin
                    if (tq <= -PI_FIX || tq > PI_FIX)
                        return f;
                    v     = sat(div_floor(tq * 2048, PI_FIX) + 2047, 0, ANG_MAX);
                    f.cnt = 2'd2;
                end
                f.b0 = {v[11:8], cfg_driver};
                f.b1 = v[7:0];
            end
            mtfe_pkg::MODE_DUTY: begin
                if (!duty_ok)
                    return f;
                // truncate toward zero, then offset to mid-scale
                m     = t * 1024;
                v     = (m >= 0) ? (m >>> FRAC) : -((-m) >>> FRAC);
                v     = sat(v + 1024, 0, DTY_MAX);
                f.b0  = {v[10:8], 1'b0, cfg_driver};
                f.b1  = v[7:0];
                f.cnt = 2'd2;
            end
            default: begin
                if (rq.duty) begin
                    if (!duty_ok)
                        return f;
                    v = sat(((t + ONE) * SPD_MID) >>> FRAC, 0, SPD_MAX);
                end else if (t > SPD_LIM) begin
                    v = SPD_MAX;
                end else if (t < -SPD_LIM) begin
                    v = 0;
                end else begin
                    v = sat(div_floor(tq * 180 * SPD_MID, PI_FIX) + SPD_MID, 0, SPD_MAX);
                end
                f.b0  = {v[18:16], rq.duty, cfg_driver};
                f.b1  = v[15:8];
                f.b2  = v[7:0];
                f.cnt = 2'd3;
            end
        endcase
        f.status         = mtfe_pkg::ST_SENT;
        last_sent_target = rq.target;
        last_sent_duty   = rq.duty;
        sent_once        = 1'b1;
        return f;
    endfunction

    // Mix of in-range, boundary, wide and repeated targets
    function automatic t_request random_request(t_request prev);
        int       pick;
        longint   base;
        t_request rq;
        pick    = $urandom_range(0, 99);
        rq.duty = 1'($urandom_range(0, 1));
        if (pick < 35) begin
            rq.target = 32'(longint'($urandom_range(0, 2 * ONE)) - ONE);
        end else if (pick < 55) begin
            rq.target = 32'(longint'($urandom_range(0, 2 * ANG_T + 4)) - (ANG_T + 2));
        end else if (pick < 70) begin
            rq.target = 32'(longint'($urandom_range(0, 2 * SPD_LIM + 8)) - (SPD_LIM + 4));
        end else if (pick < 80) begin
            case ($urandom_range(0, 5))
                0:       base = ONE;
                1:       base = -ONE;
                2:       base = ANG_T;
                3:       base = -ANG_T;
                4:       base = SPD_LIM;
                default: base = -SPD_LIM;
            endcase
            rq.target = 32'(base + longint'($urandom_range(0, 4)) - 2);
        end else if (pick < 90) begin
            rq.target = $urandom;
        end else begin
            rq = prev;
            if ($urandom_range(0, 1))
                rq.duty = !prev.duty;
        end
        return rq;
    endfunction

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        mismatches++;
        $display("%0t: %s mismatch, got 0x%02h expected 0x%02h", $time, field, got, want);
    endtask

    task automatic queue_request(logic [31:0] target, logic duty);
        t_request rq;
        rq.target = target;
        rq.duty   = duty;
        pending_requests = {pending_requests, rq};
        issued_count++;
    endtask

    // Hold until every queued request is accepted and answered, then drain the pipe
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (accepted_count != issued_count || expected_frames.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [3:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == mtfe_pkg::REG_DRIVER_NUMBER)
            cfg_driver = value;
        else
            cfg_mode = mtfe_pkg::t_mode'(value[1:0]);
    endtask

    // Driver: offer queued requests, predict each one at acceptance
    always @(posedge i_clk) begin
        logic offering;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_frames = {expected_frames, encode_frame(current_request)};
                accepted_count++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_requests.size() != 0) begin
                    current_request = pending_requests.pop_front();
                    i_target_value <= current_request.target;
                    i_duty_request <= current_request.duty;
                    offering = 1'b1;
                    send_wait = draw_wait(send_idle_pct);
                end
            end
            i_in_valid <= offering;
        end
    end

    // Monitor: check each accepted frame against the oldest prediction, drive stall
    always @(posedge i_clk) begin
        t_result want;
        logic    next_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("unexpected frame, byte_count", 8'(o_byte_count), 8'h00);
                end else begin
                    want = expected_frames.pop_front();
                    if (o_byte_zero !== want.b0)
                        report_mismatch("byte_zero", o_byte_zero, want.b0);
                    if (o_byte_one !== want.b1)
                        report_mismatch("byte_one", o_byte_one, want.b1);
                    if (o_byte_two !== want.b2)
                        report_mismatch("byte_two", o_byte_two, want.b2);
                    if (o_byte_count !== want.cnt)
                        report_mismatch("byte_count", 8'(o_byte_count), 8'(want.cnt));
                    if (o_send_status !== want.status)
                        report_mismatch("send_status", 8'(o_send_status), 8'(want.status));
                end
                recv_wait = draw_wait(recv_idle_pct);
            end
            // start a long hold-off when asked
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = LONG_HOLD;
            end
            next_stall = (recv_wait > 0) || (hold_left > 0);
            if (recv_wait > 0)
                recv_wait--;
            if (hold_left > 0)
                hold_left--;
            i_out_stall <= next_stall;
        end
    end

    // Stimulus sequence
    initial begin
        t_request prev;
        prev = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: angle mode, driver 0; first request always sent
        send_idle_pct = 30;
        recv_idle_pct = 30;
        queue_request(32'd0, 1'b0);
        queue_request(32'd0, 1'b0);
        queue_request(32'(ONE), 1'b1);
        queue_request(32'(-ONE), 1'b1);
        queue_request(32'(ONE + 1), 1'b1);
        // out-of-range request leaves the last-sent state alone
        queue_request(32'(-ONE), 1'b1);
        queue_request(32'(ANG_T), 1'b0);
        queue_request(32'(ANG_T + 1), 1'b0);
        queue_request(32'(-ANG_T), 1'b0);
        queue_request(32'(-ANG_T - 1), 1'b0);
        queue_request(32'h8000_0000, 1'b0);
        queue_request(32'h7FFF_FFFF, 1'b1);
        wait_idle();

        // Speed mode: repeat across a mode change is still suppressed
        write_reg(mtfe_pkg::REG_DRIVER_NUMBER, 4'd15);
        write_reg(mtfe_pkg::REG_ENCODER_MODE, 4'(mtfe_pkg::MODE_SPEED));
        queue_request(32'(-ANG_T), 1'b0);
        queue_request(32'(SPD_LIM), 1'b0);
        queue_request(32'(SPD_LIM + 1), 1'b0);
        queue_request(32'(-SPD_LIM), 1'b0);
        queue_request(32'(-SPD_LIM - 1), 1'b0);
        queue_request(32'(ONE), 1'b1);
        queue_request(32'(-ONE - 1), 1'b1);
        wait_idle();

        write_reg(mtfe_pkg::REG_DRIVER_NUMBER, 4'd5);
        write_reg(mtfe_pkg::REG_ENCODER_MODE, 4'(mtfe_pkg::MODE_DUTY));
        queue_request(32'(ONE), 1'b0);
        queue_request(-32'sd1, 1'b0);
        queue_request(32'(-ONE), 1'b1);
        queue_request(32'(ONE + 1), 1'b0);
        wait_idle();

        write_reg(mtfe_pkg::REG_DRIVER_NUMBER, 4'd10);
        write_reg(mtfe_pkg::REG_ENCODER_MODE, 4'(mtfe_pkg::MODE_POV));
        queue_request(32'd1, 1'b0);
        queue_request(-32'sd1, 1'b1);
        queue_request(32'h8000_0000, 1'b1);
        wait_idle();

        // Random phases, one mode each, varied idling
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                write_reg(mtfe_pkg::REG_DRIVER_NUMBER, 4'd0);
            else if (ph == PHASES - 1)
                write_reg(mtfe_pkg::REG_DRIVER_NUMBER, 4'd15);
            else
                write_reg(mtfe_pkg::REG_DRIVER_NUMBER, 4'($urandom_range(0, 15)));
            write_reg(mtfe_pkg::REG_ENCODER_MODE, 4'(ph % 4));
            if (ph % 3 == 0) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(10, 60);
                recv_idle_pct = $urandom_range(10, 60);
            end
            // back-pressure: receiver holds off while the sender keeps offering
            if (ph == 5) begin
                send_idle_pct = 0;
                hold_toggle   = !hold_toggle;
            end
            for (int k = 0; k < PHASE_REQS; k++) begin
                prev = random_request(prev);
                queue_request(prev.target, prev.duty);
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("[motor_target_frame_encoder] OK");
        else
            $display("[motor_target_frame_encoder] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("[motor_target_frame_encoder] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
sv/mtfe_pkg.sv
sv/mtfe_scale.sv
sv/mtfe_encode.sv
sv/motor_target_frame_encoder.sv
dv/tb_motor_target_frame_encoder.sv
